[sv/drive_pid_distance_rotation_unit_assert.svh]
// assertion macros for the drive pid unit checker
`ifndef DRIVE_PID_DISTANCE_ROTATION_UNIT_ASSERT_SVH
`define DRIVE_PID_DISTANCE_ROTATION_UNIT_ASSERT_SVH

// same-cycle implication
`define DRPID_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drpid assertion failed");

// next-cycle implication
`define DRPID_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drpid assertion failed");

`endif

[sv/drpid_pkg.sv]
`timescale 1ns / 1ps
package drpid_pkg;

    localparam int SUM_WIDTH = 48;

    localparam logic [31:0] DIST_GAIN_P_RST = 32'd335544;
    localparam logic [31:0] DIST_GAIN_I_RST = 32'd75;
    localparam logic [31:0] DIST_GAIN_D_RST = 32'd838861;
    localparam logic [31:0] ROT_GAIN_P_RST  = 32'd1258291;
    localparam logic [31:0] ROT_GAIN_I_RST  = 32'd503;
    localparam logic [31:0] ROT_GAIN_D_RST  = 32'd4697620;
    localparam logic [31:0] TICK_TO_CM_RST  = 32'd4008448;

    localparam int ADDR_WIDTH = 5;

    typedef enum logic [2:0] {
        REG_DIST_P = 3'd0,
        REG_DIST_I = 3'd1,
        REG_DIST_D = 3'd2,
        REG_ROT_P  = 3'd3,
        REG_ROT_I  = 3'd4,
        REG_ROT_D  = 3'd5,
        REG_TICK   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_DIST  = 2'd0,
        OP_ROT   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        logic [31:0] dist_p;
        logic [31:0] dist_i;
        logic [31:0] dist_d;
        logic [31:0] rot_p;
        logic [31:0] rot_i;
        logic [31:0] rot_d;
        logic [31:0] tick_to_cm;
    } t_gains;

    localparam logic [60:0] TERM_LIMIT = {1'b1, 60'd0};

    // clamp a product magnitude to the term limit
    function automatic logic [60:0] sat_term(input logic [64:0] m);
        logic [60:0] t;
        if (m > {4'd0, TERM_LIMIT}) begin
            t = TERM_LIMIT;
        end else begin
            t = m[60:0];
        end
        return t;
    endfunction

    // apply a sign to a clamped term
    function automatic logic [63:0] signed_term(input logic neg, input logic [60:0] t);
        logic [63:0] v;
        v = {3'd0, t};
        return neg ? (64'd0 - v) : v;
    endfunction

endpackage

[sv/drpid_mul.sv]
`timescale 1ns / 1ps
module drpid_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [32:0] i_b,
    output logic [64:0] o_p
);

    logic [64:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {33'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

[sv/drpid_regs.sv]
`timescale 1ns / 1ps
module drpid_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [drpid_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output drpid_pkg::t_gains                 o_gains
);

    drpid_pkg::t_gains r_gains;
    logic              wr_en;
    logic [2:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.dist_p     <= drpid_pkg::DIST_GAIN_P_RST;
            r_gains.dist_i     <= drpid_pkg::DIST_GAIN_I_RST;
            r_gains.dist_d     <= drpid_pkg::DIST_GAIN_D_RST;
            r_gains.rot_p      <= drpid_pkg::ROT_GAIN_P_RST;
            r_gains.rot_i      <= drpid_pkg::ROT_GAIN_I_RST;
            r_gains.rot_d      <= drpid_pkg::ROT_GAIN_D_RST;
            r_gains.tick_to_cm <= drpid_pkg::TICK_TO_CM_RST;
        end else if (wr_en) begin
            case (idx)
                drpid_pkg::REG_DIST_P: r_gains.dist_p     <= pwdata;
                drpid_pkg::REG_DIST_I: r_gains.dist_i     <= pwdata;
                drpid_pkg::REG_DIST_D: r_gains.dist_d     <= pwdata;
                drpid_pkg::REG_ROT_P:  r_gains.rot_p      <= pwdata;
                drpid_pkg::REG_ROT_I:  r_gains.rot_i      <= pwdata;
                drpid_pkg::REG_ROT_D:  r_gains.rot_d      <= pwdata;
                drpid_pkg::REG_TICK:   r_gains.tick_to_cm <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            drpid_pkg::REG_DIST_P: prdata = r_gains.dist_p;
            drpid_pkg::REG_DIST_I: prdata = r_gains.dist_i;
            drpid_pkg::REG_DIST_D: prdata = r_gains.dist_d;
            drpid_pkg::REG_ROT_P:  prdata = r_gains.rot_p;
            drpid_pkg::REG_ROT_I:  prdata = r_gains.rot_i;
            drpid_pkg::REG_ROT_D:  prdata = r_gains.rot_d;
            drpid_pkg::REG_TICK:   prdata = r_gains.tick_to_cm;
            default:               prdata = 32'd0;
        endcase
    end

    assign o_gains = r_gains;

endmodule

[sv/drive_pid_distance_rotation_unit.sv]
`timescale 1ns / 1ps
// Two-loop PID step engine for a differential drive base. Each input beat carries an
// operation (tuser), a measurement and a target; each one produces exactly one output
// beat with left drive, right drive and loop error. A distance or rotation step runs
// under a small sequencer, because every product (tick scaling, P, the two halves of
// I, D) goes one after another through a single registered 32x33 multiplier; a clear
// step or an unused operation code goes straight to the done state. The input side is
// not ready while a step runs, but a finished result waiting in the output register
// does not block a new input beat. Gains and scale are to be written over the APB port
// only while the unit is idle; the user must ensure this, as the block does not check it.
module drive_pid_distance_rotation_unit #(
    parameter int SUM_WIDTH = drpid_pkg::SUM_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [47:0]                      i_s_tdata,   // measurement, target
    input  logic [1:0]                       i_s_tuser,   // operation
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [63:0]                      o_m_tdata,   // left_drive, right_drive, loop_error
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drpid_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_SCALE  = 14'b00000000000010,
        ST_DIST   = 14'b00000000000100,
        ST_ERR    = 14'b00000000001000,
        ST_SUM    = 14'b00000000010000,
        ST_MUL_P  = 14'b00000000100000,
        ST_MUL_IL = 14'b00000001000000,
        ST_MUL_IH = 14'b00000010000000,
        ST_MUL_D  = 14'b00000100000000,
        ST_ACC_D  = 14'b00001000000000,
        ST_ACC_I  = 14'b00010000000000,
        ST_MAG    = 14'b00100000000000,
        ST_ROUND  = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } t_state;

    localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

    drpid_pkg::t_gains gains;

    t_state r_state, n_state;

    logic s_accept;
    logic load_out;

    // step payload
    logic                 r_is_dist;
    logic                 r_meas_neg;
    logic [31:0]          r_meas_mag;
    logic [15:0]          r_tgt;
    logic [31:0]          r_x;
    logic [31:0]          r_err;
    logic [32:0]          r_err_mag;
    logic [SUM_WIDTH-1:0] r_sum_cur;
    logic [SUM_WIDTH-1:0] r_sum_mag;
    logic [32:0]          r_diff;
    logic [32:0]          r_diff_mag;
    logic [63:0]          r_lo;
    logic [60:0]          r_iterm;
    logic [63:0]          r_acc;
    logic [62:0]          r_mag;
    logic [15:0]          r_v;

    // loop state
    logic [SUM_WIDTH-1:0] r_dist_sum;
    logic [SUM_WIDTH-1:0] r_rot_sum;
    logic [31:0]          r_dist_prev;
    logic [31:0]          r_rot_prev;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;

    // multiplier
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [64:0] prod;

    // combinational helpers
    logic [64:0]          rnd_sum;
    logic [56:0]          rr;
    logic [31:0]          rc;
    logic [31:0]          dist_val;
    logic [32:0]          err_wide;
    logic [31:0]          err_sat;
    logic [SUM_WIDTH-1:0] sum_sel;
    logic [31:0]          prev_sel;
    logic [SUM_WIDTH:0]   sum_wide;
    logic [SUM_WIDTH-1:0] sum_new;
    logic [32:0]          diff_new;
    logic [63:0]          sum_mag64;
    logic [64:0]          i_total;
    logic [62:0]          v_sum;
    logic [37:0]          v_mag;
    logic [15:0]          v_clamp;
    logic [15:0]          v_neg;
    logic [15:0]          left_val;
    logic [15:0]          right_val;

    drpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    drpid_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid & o_s_tready;
    assign load_out   = (r_state == ST_DONE) & (~r_out_valid | i_m_tready);

    assign sum_mag64 = 64'(r_sum_mag);

    always_comb begin
        case (r_state)
            ST_SCALE: begin
                mul_a = gains.tick_to_cm;
                mul_b = {1'b0, r_meas_mag};
            end
            ST_MUL_P: begin
                mul_a = r_is_dist ? gains.dist_p : gains.rot_p;
                mul_b = r_err_mag;
            end
            ST_MUL_IL: begin
                mul_a = r_is_dist ? gains.dist_i : gains.rot_i;
                mul_b = {1'b0, sum_mag64[31:0]};
            end
            ST_MUL_IH: begin
                mul_a = r_is_dist ? gains.dist_i : gains.rot_i;
                mul_b = {1'b0, sum_mag64[63:32]};
            end
            ST_MUL_D: begin
                mul_a = r_is_dist ? gains.dist_d : gains.rot_d;
                mul_b = r_diff_mag;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 33'd0;
            end
        endcase
    end

    always_comb begin
        // distance from the scaled tick count
        rnd_sum = prod + 65'd128;
        rr      = rnd_sum[64:8];
        if ((|rr[56:32]) || (rr[31] && (|rr[30:0]))) begin
            rc = 32'h8000_0000;
        end else begin
            rc = rr[31:0];
        end
        if (r_meas_neg) begin
            dist_val = rc[31] ? 32'h7FFF_FFFF : rc;
        end else begin
            dist_val = 32'd0 - rc;
        end

        // error
        err_wide = {r_tgt[15], r_tgt, 16'd0} - {r_x[31], r_x};
        if (err_wide[32] != err_wide[31]) begin
            err_sat = err_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            err_sat = err_wide[31:0];
        end

        // sum and difference
        sum_sel  = r_is_dist ? r_dist_sum : r_rot_sum;
        prev_sel = r_is_dist ? r_dist_prev : r_rot_prev;
        sum_wide = {sum_sel[SUM_WIDTH-1], sum_sel}
                 + {{(SUM_WIDTH-31){r_err[31]}}, r_err};
        if ($signed(sum_wide) > SUM_MAX) begin
            sum_new = SUM_MAX[SUM_WIDTH-1:0];
        end else if ($signed(sum_wide) < SUM_MIN) begin
            sum_new = SUM_MIN[SUM_WIDTH-1:0];
        end else begin
            sum_new = sum_wide[SUM_WIDTH-1:0];
        end
        diff_new = {r_err[31], r_err} - {prev_sel[31], prev_sel};

        // integral term from its two partial products
        if (|prod[64:28]) begin
            i_total = {4'd0, drpid_pkg::TERM_LIMIT};
        end else begin
            i_total = {1'b0, r_lo} + {5'd0, prod[27:0], 32'd0};
        end

        // rounding to q1.15
        v_sum = r_mag + 63'd16777216;
        v_mag = v_sum[62:25];
        if (v_mag > 38'd32767) begin
            v_clamp = 16'd32767;
        end else begin
            v_clamp = v_mag[15:0];
        end

        v_neg     = 16'd0 - r_v;
        left_val  = v_neg;
        right_val = r_is_dist ? r_v : v_neg;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_tuser)
                        drpid_pkg::OP_DIST: n_state = ST_SCALE;
                        drpid_pkg::OP_ROT:  n_state = ST_ERR;
                        default:            n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCALE:  n_state = ST_DIST;
            ST_DIST:   n_state = ST_ERR;
            ST_ERR:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_MUL_P;
            ST_MUL_P:  n_state = ST_MUL_IL;
            ST_MUL_IL: n_state = ST_MUL_IH;
            ST_MUL_IH: n_state = ST_MUL_D;
            ST_MUL_D:  n_state = ST_ACC_D;
            ST_ACC_D:  n_state = ST_ACC_I;
            ST_ACC_I:  n_state = ST_MAG;
            ST_MAG:    n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_dist_sum  <= '0;
            r_rot_sum   <= '0;
            r_dist_prev <= '0;
            r_rot_prev  <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (s_accept && (i_s_tuser == drpid_pkg::OP_CLEAR)) begin
                r_dist_sum  <= '0;
                r_rot_sum   <= '0;
                r_dist_prev <= '0;
                r_rot_prev  <= '0;
            end else if (r_state == ST_SUM) begin
                if (r_is_dist) begin
                    r_dist_sum  <= sum_new;
                    r_dist_prev <= r_err;
                end else begin
                    r_rot_sum  <= sum_new;
                    r_rot_prev <= r_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    r_is_dist  <= (i_s_tuser == drpid_pkg::OP_DIST);
                    r_meas_neg <= i_s_tdata[31];
                    r_meas_mag <= i_s_tdata[31] ? (32'd0 - i_s_tdata[31:0]) : i_s_tdata[31:0];
                    r_tgt      <= i_s_tdata[47:32];
                    r_x        <= i_s_tdata[31:0];
                    r_err      <= 32'd0;
                    r_v        <= 16'd0;
                end
            end
            ST_DIST: r_x <= dist_val;
            ST_ERR:  r_err <= err_sat;
            ST_SUM: begin
                r_sum_cur <= sum_new;
                r_diff    <= diff_new;
                r_err_mag <= r_err[31] ? (33'd0 - {1'b1, r_err}) : {1'b0, r_err};
                r_acc     <= 64'd0;
            end
            ST_MUL_P: begin
                r_sum_mag  <= r_sum_cur[SUM_WIDTH-1] ? ('0 - r_sum_cur) : r_sum_cur;
                r_diff_mag <= r_diff[32] ? (33'd0 - r_diff) : r_diff;
            end
            ST_MUL_IL: begin
                r_acc <= r_acc + drpid_pkg::signed_term(r_err[31], drpid_pkg::sat_term(prod));
            end
            ST_MUL_IH: r_lo <= prod[63:0];
            ST_MUL_D:  r_iterm <= drpid_pkg::sat_term(i_total);
            ST_ACC_D: begin
                r_acc <= r_acc + drpid_pkg::signed_term(r_diff[32], drpid_pkg::sat_term(prod));
            end
            ST_ACC_I: begin
                r_acc <= r_acc + drpid_pkg::signed_term(r_sum_cur[SUM_WIDTH-1], r_iterm);
            end
            ST_MAG:   r_mag <= r_acc[63] ? (63'd0 - r_acc[62:0]) : r_acc[62:0];
            ST_ROUND: r_v <= r_acc[63] ? (16'd0 - v_clamp) : v_clamp;
            default: ;
        endcase
        if (load_out) begin
            r_out_data <= {r_err, right_val, left_val};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[sv/drpid_checker.sv]
`timescale 1ns / 1ps
`include "drive_pid_distance_rotation_unit_assert.svh"
module drpid_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [47:0]                      i_s_tdata,
    input logic [1:0]                       i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [63:0]                      o_m_tdata,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [drpid_pkg::ADDR_WIDTH-1:0] paddr,
    input logic [31:0]                      pwdata,
    input logic [31:0]                      prdata,
    input logic                             pready
);

    `DRPID_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `DRPID_ASSERT_NEXT(a_busy_after_beat, i_s_tvalid && o_s_tready, !o_s_tready)
    `DRPID_ASSERT_NOW(a_drive_range, o_m_tvalid, (o_m_tdata[15:0] != 16'h8000) && (o_m_tdata[31:16] != 16'h8000))
    `DRPID_ASSERT_NOW(a_drive_sides, o_m_tvalid, (o_m_tdata[15:0] == o_m_tdata[31:16]) || ((o_m_tdata[15:0] + o_m_tdata[31:16]) == 16'd0))

endmodule

bind drive_pid_distance_rotation_unit drpid_checker u_drpid_checker (.*);
